// ===== src/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int unsigned ARENA_BYTES = 4096;
    localparam int unsigned ADDR_W      = $clog2(ARENA_BYTES);
    localparam int unsigned SIZE_W      = ADDR_W + 1;
    localparam int unsigned WORD_BYTES  = 4;
    localparam int unsigned HDR_BYTES   = 3 * WORD_BYTES;
    localparam int unsigned BYTE_W      = 8;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SIZE_W-1:0]   count;
        logic [ADDR_W-1:0]   pos;
        logic [BYTE_W-1:0]   fill;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]   offset;
        logic [BYTE_W-1:0]   rbyte;
        logic                ok;
    } t_rsp;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } t_mem_wr;

endpackage
`default_nettype wire

// ===== src/ffa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/ffa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_seq
// Command sequencer: walks the in-band block list through the arena RAM,
// reading header words byte by byte and writing headers, links and data.
// ----------------------------------------------------------------------------
module ffa_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ffa_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_cmd_valid,
    input  wire ffa_pkg::t_cmd               i_cmd,
    output      logic                        o_busy,
    output      logic                        o_rsp_valid,
    output      ffa_pkg::t_rsp               o_rsp,
    input  wire logic                        i_rsp_take,
    output      ffa_pkg::t_mem_wr            o_mem_wr,
    output      logic [ffa_pkg::ADDR_W-1:0]  o_mem_raddr,
    input  wire logic [ffa_pkg::BYTE_W-1:0]  i_mem_rdata
);

    localparam int unsigned AW = ffa_pkg::ADDR_W;
    localparam int unsigned SW = ffa_pkg::SIZE_W;
    localparam logic [SW:0] L_HDR  = (SW+1)'(ffa_pkg::HDR_BYTES);
    localparam logic [SW-1:0] L_CAP = SW'(ffa_pkg::ARENA_BYTES);
    localparam logic [AW-1:0] L_LAST = AW'(ffa_pkg::ARENA_BYTES - 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RDB, S_RD0, S_RD1, S_RD2,
        S_AL_SZ, S_AL_NX, S_HDR, S_LINK,
        S_FD_CHK, S_FD_NX, S_FR_NX, S_FR_SZ,
        S_FL_TOP, S_FL_SZ, S_MSET, S_FL_NX, S_DONE
    } t_state;

    t_state             r_state, r_ret;
    logic [SW-1:0]      r_span;
    logic [AW-1:0]      r_first;
    logic               r_empty;
    logic [AW-1:0]      r_clr;
    ffa_pkg::t_op       r_op;
    logic [SW-1:0]      r_cnt;
    logic [AW-1:0]      r_pos;
    logic [7:0]         r_fv;
    logic [AW-1:0]      r_h, r_ph, r_nx, r_ra;
    logic               r_hasprev;
    logic [SW-1:0]      r_sz, r_word;
    logic [7:0]         r_lo;
    logic [3:0]         r_k;
    logic [AW-1:0]      r_ha, r_hn, r_hp;
    logic [SW-1:0]      r_hs;
    logic [AW-1:0]      r_l1a, r_l1v, r_l2a, r_l2v;
    logic               r_l1en, r_l2en;
    logic [AW-1:0]      r_ma;
    logic [SW-1:0]      r_mlen;
    logic [7:0]         r_mval;
    ffa_pkg::t_rsp      r_rsp;

    // Link word of a header, or zero when it does not point forward
    // to a header that lies inside the arena in use.
    function automatic logic [AW-1:0] next_ok(input logic [SW-1:0] w,
                                              input logic [AW-1:0] h,
                                              input logic [SW-1:0] e);
        logic bad;
        bad = (w == '0) || (w <= {1'b0, h}) || (({1'b0, w} + L_HDR) > {1'b0, e});
        return bad ? '0 : w[AW-1:0];
    endfunction

    // Little-endian byte of a header word; the upper two bytes are zero.
    function automatic logic [7:0] word_byte(input logic [SW-1:0] v,
                                             input logic [1:0] b);
        logic [7:0] res;
        res = '0;
        if (b == 2'd0) res = v[7:0];
        else if (b == 2'd1) res = 8'(v[SW-1:8]);
        return res;
    endfunction

    logic [SW:0]   c_need_in, c_need, c_end, c_room;
    logic [AW-1:0] c_nx;
    logic [SW-1:0] c_flen, c_fsz, c_fw;
    logic [SW-1:0] c_hval;

    always_comb begin
        c_need_in = L_HDR + {1'b0, i_cmd.count};
        c_need    = L_HDR + {1'b0, r_cnt};
        c_end     = {2'b0, r_h} + L_HDR + {1'b0, r_sz};
        c_nx      = next_ok(r_word, r_h, r_span);
        c_room    = {1'b0, r_span} - {2'b0, r_h} - L_HDR;
        c_flen    = ({1'b0, r_word} > c_room) ? (r_span - {1'b0, r_h})
                                              : SW'(L_HDR + {1'b0, r_word});
        c_fsz     = ({1'b0, r_word} > c_room) ? c_room[SW-1:0] : r_word;
        c_fw      = (r_cnt < c_fsz) ? r_cnt : c_fsz;
        unique case (r_k[3:2])
            2'd0:    c_hval = {1'b0, r_hn};
            2'd1:    c_hval = {1'b0, r_hp};
            default: c_hval = r_hs;
        endcase
    end

    // RAM ports
    always_comb begin
        o_mem_wr = '0;
        unique case (r_state)
            S_CLR: begin
                o_mem_wr.we   = 1'b1;
                o_mem_wr.addr = r_clr;
            end
            S_HDR: begin
                o_mem_wr.we   = 1'b1;
                o_mem_wr.addr = r_ha + AW'(r_k);
                o_mem_wr.data = word_byte(c_hval, r_k[1:0]);
            end
            S_LINK: begin
                o_mem_wr.we   = r_k[2] ? r_l2en : r_l1en;
                o_mem_wr.addr = (r_k[2] ? r_l2a : r_l1a) + AW'(r_k[1:0]);
                o_mem_wr.data = word_byte({1'b0, r_k[2] ? r_l2v : r_l1v}, r_k[1:0]);
            end
            S_MSET: begin
                o_mem_wr.we   = (r_mlen != '0);
                o_mem_wr.addr = r_ma;
                o_mem_wr.data = r_mval;
            end
            default: ;
        endcase
        unique case (r_state)
            S_IDLE:  o_mem_raddr = i_cmd.pos;
            S_RD1:   o_mem_raddr = r_ra + AW'(1);
            default: o_mem_raddr = r_ra;
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_clr   <= '0;
            r_span  <= L_CAP;
            r_first <= '0;
            r_empty <= 1'b1;
            r_k     <= '0;
        end else if (i_cfg_wr_en) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_span  <= (i_cfg_wr_data > L_CAP) ? L_CAP : i_cfg_wr_data;
            r_first <= '0;
            r_empty <= 1'b1;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == L_LAST) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op      <= i_cmd.op;
                        r_cnt     <= i_cmd.count;
                        r_pos     <= i_cmd.pos;
                        r_fv      <= i_cmd.fill;
                        r_h       <= r_first;
                        r_hasprev <= 1'b0;
                        r_ph      <= '0;
                        r_k       <= '0;
                        r_l1en    <= 1'b0;
                        r_l2en    <= 1'b0;
                        r_hs      <= i_cmd.count;
                        r_hp      <= '0;
                        r_ha      <= '0;
                        unique case (i_cmd.op)
                            ffa_pkg::OP_ALLOC: begin
                                if (r_empty) begin
                                    if (c_need_in > {1'b0, r_span}
                                        || L_HDR >= {1'b0, r_span}) begin
                                        r_rsp   <= '0;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_hn    <= '0;
                                        r_first <= '0;
                                        r_empty <= 1'b0;
                                        r_rsp   <= '{offset: AW'(L_HDR), rbyte: 8'h00,
                                                     ok: 1'b1};
                                        r_state <= S_HDR;
                                    end
                                end else if (c_need_in <= {2'b0, r_first}) begin
                                    r_hn    <= r_first;
                                    r_l1en  <= 1'b1;
                                    r_l1a   <= r_first + AW'(4);
                                    r_l1v   <= '0;
                                    r_first <= '0;
                                    r_rsp   <= '{offset: AW'(L_HDR), rbyte: 8'h00,
                                                 ok: 1'b1};
                                    r_state <= S_HDR;
                                end else begin
                                    r_rsp   <= '0;
                                    r_ra    <= r_first + AW'(8);
                                    r_ret   <= S_AL_SZ;
                                    r_state <= S_RD0;
                                end
                            end
                            ffa_pkg::OP_FREE, ffa_pkg::OP_FILL: begin
                                r_rsp   <= '0;
                                r_state <= r_empty ? S_DONE : S_FD_CHK;
                            end
                            ffa_pkg::OP_READ: begin
                                r_rsp   <= '0;
                                r_state <= ({1'b0, i_cmd.pos} < r_span) ? S_RDB : S_DONE;
                            end
                        endcase
                    end
                end
                S_RDB: begin
                    r_rsp.rbyte <= i_mem_rdata;
                    r_rsp.ok    <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_lo    <= i_mem_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_word  <= {i_mem_rdata[SW-9:0], r_lo};
                    r_state <= r_ret;
                end
                S_AL_SZ: begin
                    r_sz    <= r_word;
                    r_ra    <= r_h;
                    r_ret   <= S_AL_NX;
                    r_state <= S_RD0;
                end
                S_AL_NX: begin
                    if (c_nx != '0) begin
                        if ({2'b0, c_nx} >= c_end && ({2'b0, c_nx} - c_end) >= c_need) begin
                            r_ha         <= c_end[AW-1:0];
                            r_hn         <= c_nx;
                            r_hp         <= r_h;
                            r_l1en       <= 1'b1;
                            r_l1a        <= r_h;
                            r_l1v        <= c_end[AW-1:0];
                            r_l2en       <= 1'b1;
                            r_l2a        <= c_nx + AW'(4);
                            r_l2v        <= c_end[AW-1:0];
                            r_rsp.offset <= c_end[AW-1:0] + AW'(L_HDR);
                            r_rsp.ok     <= 1'b1;
                            r_state      <= S_HDR;
                        end else begin
                            r_h     <= c_nx;
                            r_ra    <= c_nx + AW'(8);
                            r_ret   <= S_AL_SZ;
                            r_state <= S_RD0;
                        end
                    end else if (c_end <= {1'b0, r_span}
                                 && c_need <= ({1'b0, r_span} - c_end)
                                 && (c_end + L_HDR) < {1'b0, r_span}) begin
                        r_ha         <= c_end[AW-1:0];
                        r_hn         <= '0;
                        r_hp         <= r_h;
                        r_l1en       <= 1'b1;
                        r_l1a        <= r_h;
                        r_l1v        <= c_end[AW-1:0];
                        r_rsp.offset <= c_end[AW-1:0] + AW'(L_HDR);
                        r_rsp.ok     <= 1'b1;
                        r_state      <= S_HDR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_HDR: begin
                    if (r_k == 4'd11) begin
                        r_k     <= '0;
                        r_state <= S_LINK;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_LINK: begin
                    if (r_k == 4'd7) begin
                        r_k     <= '0;
                        r_state <= (r_op == ffa_pkg::OP_FREE) ? S_MSET : S_DONE;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_FD_CHK: begin
                    if (({1'b0, r_h} + SW'(L_HDR)) == {1'b0, r_pos}) begin
                        r_rsp.ok <= 1'b1;
                        if (r_op == ffa_pkg::OP_FREE) begin
                            r_ra    <= r_h;
                            r_ret   <= S_FR_NX;
                            r_state <= S_RD0;
                        end else begin
                            r_state <= S_FL_TOP;
                        end
                    end else begin
                        r_ra    <= r_h;
                        r_ret   <= S_FD_NX;
                        r_state <= S_RD0;
                    end
                end
                S_FD_NX: begin
                    if (c_nx == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ph      <= r_h;
                        r_hasprev <= 1'b1;
                        r_h       <= c_nx;
                        r_state   <= S_FD_CHK;
                    end
                end
                S_FR_NX: begin
                    r_nx    <= c_nx;
                    r_ra    <= r_h + AW'(8);
                    r_ret   <= S_FR_SZ;
                    r_state <= S_RD0;
                end
                S_FR_SZ: begin
                    r_l1en <= r_hasprev;
                    r_l1a  <= r_ph;
                    r_l1v  <= r_nx;
                    r_l2en <= (r_nx != '0);
                    r_l2a  <= r_nx + AW'(4);
                    r_l2v  <= r_hasprev ? r_ph : '0;
                    if (!r_hasprev) begin
                        if (r_nx == '0) begin
                            r_empty <= 1'b1;
                            r_first <= '0;
                        end else begin
                            r_first <= r_nx;
                        end
                    end
                    r_ma    <= r_h;
                    r_mval  <= '0;
                    r_mlen  <= c_flen;
                    r_k     <= '0;
                    r_state <= S_LINK;
                end
                S_FL_TOP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ra    <= r_h + AW'(8);
                        r_ret   <= S_FL_SZ;
                        r_state <= S_RD0;
                    end
                end
                S_FL_SZ: begin
                    r_ma    <= r_h + AW'(L_HDR);
                    r_mlen  <= c_fw;
                    r_mval  <= r_fv;
                    r_cnt   <= r_cnt - c_fw;
                    r_state <= S_MSET;
                end
                S_MSET: begin
                    if (r_mlen != '0) begin
                        r_ma   <= r_ma + AW'(1);
                        r_mlen <= r_mlen - SW'(1);
                    end else if (r_op == ffa_pkg::OP_FILL) begin
                        r_ra    <= r_h;
                        r_ret   <= S_FL_NX;
                        r_state <= S_RD0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FL_NX: begin
                    if (c_nx == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_h     <= c_nx;
                        r_state <= S_FL_TOP;
                    end
                end
                S_DONE: begin
                    if (i_rsp_take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An empty list always points at the arena base.
    a_empty_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_first == '0))
        else $error("empty list with nonzero first block");

    // The idle sequencer leaves the arena untouched.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem_wr.we)
        else $error("arena write while idle");

    // New headers always lie inside the arena in use.
    a_hdr_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> ({1'b0, o_mem_wr.addr} < r_span))
        else $error("header written beyond arena end");

endmodule
`default_nettype wire

// ===== src/first_fit_arena_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// Byte arena with in-band block headers, first-fit alloc, free, fill, read.
// ----------------------------------------------------------------------------
// Operation: read passes the arena byte through the RAM read register and the
//   sequencer result into the output register; alloc walks the block list,
//   reading the size and link words of each block, then writes the header and
//   links; free searches the list, rewrites the links, then zeroes header plus
//   data one byte a cycle; fill writes its value into the data of each block.
// Throughput: one transaction at a time; the arena RAM, read one byte per
//   cycle, sets the pace of every list walk and byte sweep.
// Reset and every arena_size write start a clearing pass over the whole
//   arena, during which no transaction is accepted.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [12:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [12:0] i_byte_count,
    input  wire logic [11:0] i_position,
    input  wire logic [7:0]  i_fill_value,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [11:0] o_data_offset,
    output      logic [7:0]  o_read_byte,
    output      logic        o_ok
);

    ffa_pkg::t_cmd    w_cmd;
    ffa_pkg::t_rsp    w_rsp;
    ffa_pkg::t_mem_wr w_mem_wr;
    logic [ffa_pkg::ADDR_W-1:0] w_mem_raddr;
    logic [ffa_pkg::BYTE_W-1:0] w_mem_rdata;
    logic w_busy, w_rsp_valid, w_rsp_take;

    logic          r_out_valid;
    ffa_pkg::t_rsp r_out;

    // The command fields travel together into the sequencer.
    assign w_cmd.op    = ffa_pkg::t_op'(i_op);
    assign w_cmd.count = i_byte_count;
    assign w_cmd.pos   = i_position;
    assign w_cmd.fill  = i_fill_value;

    // The sequencer takes a new transaction only when idle; a finished result
    // moves into the output register as soon as that register is free, so
    // the next command can start while the result still waits downstream.
    assign o_in_stall = w_busy;
    assign w_rsp_take = !r_out_valid || !i_out_stall;

    ffa_ram #(
        .WIDTH (ffa_pkg::BYTE_W),
        .DEPTH (ffa_pkg::ARENA_BYTES)
    ) u_arena (
        .i_clk   (i_clk),
        .i_we    (w_mem_wr.we),
        .i_waddr (w_mem_wr.addr),
        .i_wdata (w_mem_wr.data),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    ffa_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (i_in_valid),
        .i_cmd         (w_cmd),
        .o_busy        (w_busy),
        .o_rsp_valid   (w_rsp_valid),
        .o_rsp         (w_rsp),
        .i_rsp_take    (w_rsp_take),
        .o_mem_wr      (w_mem_wr),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata)
    );

    // Output register: loaded when the sequencer hands over a result,
    // emptied when the downstream side takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_valid && w_rsp_take) begin
            r_out_valid <= 1'b1;
            r_out       <= w_rsp;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_offset = r_out.offset;
    assign o_read_byte   = r_out.rbyte;
    assign o_ok          = r_out.ok;

endmodule
`default_nettype wire
